[design/kcq_pkg.sv]
// kcq_pkg: shared types and constants for the k-means colour quantizer.
// No dependencies; imported by kcq_cell and kmeans_color_quantizer.
`timescale 1ns / 1ps

package kcq_pkg;

  // Parameter defaults
  localparam int DEF_CLUSTERS   = 64;
  localparam int DEF_PASS_LOG2  = 20;

  // Register and field widths
  localparam int ACTIVE_W       = 7;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;
  localparam int DIST_W         = 18;
  localparam int SLOT_W         = 6;
  localparam int QUO_W          = 9;   // eight quotient bits plus saturation bit
  localparam logic [3:0] QUO_TOP = 4'd8;

  // Command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_ACC  = 2'd1;
  localparam logic [1:0] CMD_CLS  = 2'd2;
  localparam logic [1:0] CMD_UPD  = 2'd3;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic       acc;       // accumulate pixel into the cell named by acc_idx
    logic       div_load;  // load divider remainders from the sums
    logic       div_step;  // one restoring division step
    logic [3:0] div_bit;   // quotient bit handled by this step
    logic       div_done;  // write means back and clear sums and counts
  } ctl_t;

endpackage

[design/kcq_cell.sv]
// kcq_cell: one centroid cell of the chain: centroid, sums, count and divider.
// Depends on kcq_pkg.
`timescale 1ns / 1ps

module kcq_cell import kcq_pkg::*; #(
  parameter int IDX  = 0,
  parameter int IDXW = 6,
  parameter int LW   = 7,
  parameter int CNTW = 21,
  parameter int SUMW = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LW-1:0]     lim,
  input  ctl_t              ctl,
  input  logic [IDXW-1:0]   acc_idx,
  input  logic [23:0]       acc_px,
  input  logic              i_v,
  input  logic [1:0]        i_cmd,
  input  logic [SLOT_W-1:0] i_slot,
  input  logic [23:0]       i_px,
  input  logic [IDXW-1:0]   i_best,
  input  logic [DIST_W-1:0] i_dist,
  input  logic [23:0]       i_col,
  input  logic [LW-1:0]     i_empty,
  output logic              o_v,
  output logic [1:0]        o_cmd,
  output logic [SLOT_W-1:0] o_slot,
  output logic [23:0]       o_px,
  output logic [IDXW-1:0]   o_best,
  output logic [DIST_W-1:0] o_dist,
  output logic [23:0]       o_col,
  output logic [LW-1:0]     o_empty
);

  localparam logic [CNTW-1:0] CNT_MAX = {CNTW{1'b1}};
  localparam logic [SUMW-1:0] SUM_MAX = {SUMW{1'b1}};

  logic              v_r;
  logic [1:0]        cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [23:0]       px_r;
  logic [IDXW-1:0]   best_r;
  logic [DIST_W-1:0] dist_r;
  logic [23:0]       col_r;
  logic [LW-1:0]     empty_r;

  logic [23:0]       cent_r;
  logic [SUMW-1:0]   sum_r [3];
  logic [CNTW-1:0]   cnt_r;
  logic [SUMW-1:0]   rem_r [3];
  logic [QUO_W-1:0]  quo_r [3];

  logic              active;
  logic [DIST_W-1:0] dist_cur;
  logic              take;

  assign active = LW'(IDX) < lim;

  // Squared distance from the passing pixel to this centroid
  always_comb begin
    logic [7:0]  a, b, d;
    logic [15:0] sq;
    dist_cur = '0;
    for (int c = 0; c < 3; c++) begin
      a = cent_r[8*c +: 8];
      b = i_px[8*c +: 8];
      d = (a > b) ? a - b : b - a;
      sq = d * d;
      dist_cur = dist_cur + DIST_W'(sq);
    end
  end

  assign take = (i_cmd inside {CMD_ACC, CMD_CLS}) && active &&
                ((IDX == 0) || (dist_cur < i_dist));

  // Token stage: hand the transaction to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= i_v;
    end
    cmd_r   <= i_cmd;
    slot_r  <= i_slot;
    px_r    <= i_px;
    best_r  <= take ? IDXW'(IDX) : i_best;
    dist_r  <= take ? dist_cur : i_dist;
    col_r   <= take ? cent_r : i_col;
    empty_r <= (i_cmd == CMD_UPD && active && cnt_r == '0) ? i_empty + 1'b1 : i_empty;
  end

  // Centroid, sums, count and restoring divider
  always_ff @(posedge clk) begin
    logic [SUMW:0] shl;
    logic [SUMW:0] s;
    if (!rst_n) begin
      cent_r <= '0;
      cnt_r  <= '0;
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
    end else begin
      if (i_v && i_cmd == CMD_LOAD && IDX < 64 && i_slot == SLOT_W'(IDX))
        cent_r <= i_px;
      if (ctl.acc && acc_idx == IDXW'(IDX) && cnt_r < CNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
        for (int c = 0; c < 3; c++) begin
          s = {1'b0, sum_r[c]} + (SUMW+1)'(acc_px[8*c +: 8]);
          sum_r[c] <= s[SUMW] ? SUM_MAX : s[SUMW-1:0];
        end
      end
      if (ctl.div_done) begin
        if (active && cnt_r != '0)
          for (int c = 0; c < 3; c++)
            cent_r[8*c +: 8] <= quo_r[c][QUO_W-1] ? 8'hFF : quo_r[c][7:0];
        cnt_r <= '0;
        for (int c = 0; c < 3; c++) sum_r[c] <= '0;
      end
    end
    // divider datapath
    for (int c = 0; c < 3; c++) begin
      shl = (SUMW+1)'(cnt_r) << ctl.div_bit;
      if (ctl.div_load) begin
        rem_r[c] <= sum_r[c];
        quo_r[c] <= '0;
      end else if (ctl.div_step && {1'b0, rem_r[c]} >= shl) begin
        rem_r[c] <= rem_r[c] - shl[SUMW-1:0];
        quo_r[c][ctl.div_bit] <= 1'b1;
      end
    end
  end

  assign o_v     = v_r;
  assign o_cmd   = cmd_r;
  assign o_slot  = slot_r;
  assign o_px    = px_r;
  assign o_best  = best_r;
  assign o_dist  = dist_r;
  assign o_col   = col_r;
  assign o_empty = empty_r;

endmodule

[design/kmeans_color_quantizer.sv]
// kmeans_color_quantizer: top level, sequencer and chain of centroid cells.
// Depends on kcq_pkg and kcq_cell.
`timescale 1ns / 1ps

// Usage:
//   in_*  : command transactions. in_tuser = cmd; in_tdata = slot, red, green,
//           blue. One transaction is handled at a time.
//   out_* : one result per command, held in an output register until taken.
//   cfg_* : write of active_clusters (bits 6:0), taken only while idle; a
//           waiting write holds off the input channel.
// A transaction enters cell 0 and walks one cell per cycle down the chain of
// CLUSTERS cells, carrying the best match so far; the chain length sets the
// latency. An update then also runs the nine-step restoring divider in every
// cell and writes the means back. A new command is accepted once the previous
// result sits in the output register, even if the receiver has not yet taken
// it; a stalled receiver holds the next result back until the register frees.
// Reset clears centroids, sums, counts and sets active_clusters to 64.
module kmeans_color_quantizer import kcq_pkg::*; #(
  parameter int CLUSTERS         = DEF_CLUSTERS,
  parameter int PASS_PIXELS_LOG2 = DEF_PASS_LOG2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // slot[5:0], red[13:6], green[21:14], blue[29:22]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // cluster[5:0], red[13:6], green[21:14], blue[29:22],
                                  // distance[47:30], empty_count[54:48]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // active_clusters[6:0]
);

  localparam int IDXW = $clog2(CLUSTERS);
  localparam int LWC  = $clog2(CLUSTERS + 1);
  localparam int LW   = (LWC > ACTIVE_W) ? LWC : ACTIVE_W;
  localparam int CNTW = PASS_PIXELS_LOG2 + 1;
  localparam int SUMW = PASS_PIXELS_LOG2 + 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [3:0]          bit_r, bit_nxt;
  logic [ACTIVE_W-1:0] active_r;
  logic [LW-1:0]       lim;
  logic [1:0]          cmd_r;
  logic [23:0]         px_r;
  logic [55:0]         res_r;
  logic                out_valid_r;
  logic [55:0]         out_data_r;
  logic                in_acc;
  ctl_t                ctl;

  // Chain links
  logic              ch_v     [0:CLUSTERS];
  logic [1:0]        ch_cmd   [0:CLUSTERS];
  logic [SLOT_W-1:0] ch_slot  [0:CLUSTERS];
  logic [23:0]       ch_px    [0:CLUSTERS];
  logic [IDXW-1:0]   ch_best  [0:CLUSTERS];
  logic [DIST_W-1:0] ch_dist  [0:CLUSTERS];
  logic [23:0]       ch_col   [0:CLUSTERS];
  logic [LW-1:0]     ch_empty [0:CLUSTERS];

  // Configuration only while the chain is empty; it wins over a new command
  assign cfg_tready = (state_r == S_IDLE);
  assign in_tready  = (state_r == S_IDLE) && !cfg_tvalid;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Effective active count
  always_comb begin
    if (active_r == '0) lim = LW'(1);
    else if (LW'(active_r) > LW'(CLUSTERS)) lim = LW'(CLUSTERS);
    else lim = LW'(active_r);
  end

  assign ch_v[0]     = in_acc;
  assign ch_cmd[0]   = in_tuser;
  assign ch_slot[0]  = in_tdata[5:0];
  assign ch_px[0]    = {in_tdata[29:22], in_tdata[21:14], in_tdata[13:6]};
  assign ch_best[0]  = '0;
  assign ch_dist[0]  = '0;
  assign ch_col[0]   = '0;
  assign ch_empty[0] = '0;

  for (genvar i = 0; i < CLUSTERS; i++) begin : g_cell
    kcq_cell #(
      .IDX (i), .IDXW (IDXW), .LW (LW), .CNTW (CNTW), .SUMW (SUMW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .lim     (lim),
      .ctl     (ctl),
      .acc_idx (ch_best[CLUSTERS]),
      .acc_px  (px_r),
      .i_v     (ch_v[i]),     .i_cmd (ch_cmd[i]),   .i_slot (ch_slot[i]),
      .i_px    (ch_px[i]),    .i_best (ch_best[i]), .i_dist (ch_dist[i]),
      .i_col   (ch_col[i]),   .i_empty (ch_empty[i]),
      .o_v     (ch_v[i+1]),   .o_cmd (ch_cmd[i+1]), .o_slot (ch_slot[i+1]),
      .o_px    (ch_px[i+1]),  .o_best (ch_best[i+1]), .o_dist (ch_dist[i+1]),
      .o_col   (ch_col[i+1]), .o_empty (ch_empty[i+1])
    );
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    bit_nxt      = bit_r;
    ctl          = '0;
    ctl.div_bit  = bit_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RUN;
      S_RUN: begin
        if (ch_v[CLUSTERS]) begin
          ctl.acc      = (cmd_r == CMD_ACC);
          ctl.div_load = (cmd_r == CMD_UPD);
          bit_nxt      = QUO_TOP;
          state_nxt    = (cmd_r == CMD_UPD) ? S_DIV : S_PUSH;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        bit_nxt      = bit_r - 1'b1;
        if (bit_r == '0) state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.div_done = 1'b1;
        state_nxt    = S_PUSH;
      end
      S_PUSH: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid && cfg_tready) active_r <= cfg_tdata[ACTIVE_W-1:0];
      if (state_r == S_PUSH && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    bit_r <= bit_nxt;
    if (in_acc) begin
      cmd_r <= in_tuser;
      px_r  <= ch_px[0];
    end
    // capture the result as the transaction leaves the chain
    if (state_r == S_RUN && ch_v[CLUSTERS]) begin
      if (cmd_r inside {CMD_ACC, CMD_CLS})
        res_r <= {8'b0, ch_dist[CLUSTERS], ch_col[CLUSTERS], 6'(ch_best[CLUSTERS])};
      else if (cmd_r == CMD_UPD)
        res_r <= {1'b0, 7'(ch_empty[CLUSTERS]), 48'b0};
      else
        res_r <= '0;
    end
    if (state_r == S_PUSH && (!out_valid_r || out_tready)) out_data_r <= res_r;
  end

`ifndef SYNTH
  a_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    ch_v[CLUSTERS] |-> state_r == S_RUN) else $error("token left chain outside run");
  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_RUN) else $error("accept did not start run");
  a_done_push: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> state_r == S_PUSH) else $error("update did not finish");
  a_acc_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc |-> cmd_r == CMD_ACC) else $error("accumulate on wrong command");
`endif

endmodule
